@@ rtl/lfoap_pkg.sv @@
// ----------------------------------------------------------------------------
// lfoap_pkg
// Shared types, codes and constants of the swept allpass phaser: register
// indexes, sequencer states, divider handshake, saturation and sine helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfoap_pkg;

   localparam int STATE_W    = 24;
   localparam int A1_W       = 18;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [A1_W-1:0] A1_MAX = 18'h3ffff;

   localparam logic signed [15:0] D_MIN_RESET     = 16'sd1365;
   localparam logic signed [15:0] D_MAX_RESET     = 16'sd1638;
   localparam logic [31:0]        PHASE_STEP_RESET = 32'd8948;
   localparam logic [14:0]        FB_GAIN_RESET    = 15'd22938;
   localparam logic [15:0]        WET_MIX_RESET    = 16'd9830;
   localparam logic [15:0]        WET_FULL         = 16'h8000;

   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SERIES_DIV [1:9] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                64'd156, 64'd210, 64'd272, 64'd342};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_D_MIN         = 3'd0,
      CSR_D_MAX         = 3'd1,
      CSR_PHASE_STEP    = 3'd2,
      CSR_FEEDBACK_GAIN = 3'd3,
      CSR_WET_MIX       = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROM,
      ST_SWEEP,
      ST_DIV,
      ST_PRIME,
      ST_STAGE_A,
      ST_STAGE_B,
      ST_WB,
      ST_MIX,
      ST_OUT
   } phaser_state_type;

   typedef struct packed {
      logic        start;
      logic [16:0] num;
      logic [15:0] den;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [A1_W-1:0] quot;
   } div_rsp_type;

   function automatic logic signed [STATE_W-1:0] sat24(input logic signed [47:0] v);
      logic signed [STATE_W-1:0] r;
      if (v > 48'sd8388607) begin
         r = 24'sh7fffff;
      end else if (v < -48'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[STATE_W-1:0];
      end
      return r;
   endfunction

   // q30 taylor series, evaluated at elaboration for the rom contents
   function automatic logic signed [15:0] sine_q15(input logic [63:0] theta);
      logic [63:0]        th;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic               neg;
      th  = theta;
      neg = 1'b0;
      if (th > PI_Q30) begin
         th  = th - PI_Q30;
         neg = 1'b1;
      end
      if (th > HALF_PI_Q30) begin
         th = (th > PI_Q30) ? 64'd0 : PI_Q30 - th;
      end
      x2   = (th * th) >> 30;
      term = th;
      sum  = $signed(th);
      for (int n = 1; n <= 9; n++) begin
         term = ((term * x2) >> 30) / SERIES_DIV[n];
         if ((n & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 64'sd0) begin
         sum = 64'sd0;
      end
      if (sum > 64'sd1073741824) begin
         sum = 64'sd1073741824;
      end
      sum = (sum * 64'sd32767 + 64'sd536870912) >>> 30;
      return neg ? 16'(-sum) : 16'(sum);
   endfunction

endpackage

`default_nettype wire

@@ rtl/lfoap_sine_rom.sv @@
// ----------------------------------------------------------------------------
// lfoap_sine_rom
// Q1.15 sine table of SINE_TABLE_SIZE entries with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfoap_sine_rom #(
   parameter  int SINE_TABLE_SIZE = 1024,
   localparam int IDX_W           = $clog2(SINE_TABLE_SIZE)
) (
   input  wire logic                    clock,
   input  wire logic                    rd_en,
   input  wire logic [IDX_W-1:0]        rd_addr,
   output logic signed [15:0]           rd_data
);
   import lfoap_pkg::*;

   logic signed [15:0] rom_tbl [SINE_TABLE_SIZE];
   logic signed [15:0] rd_data_ff;

   for (genvar k = 0; k < SINE_TABLE_SIZE; k++) begin : g_entry
      localparam logic [63:0] THETA = (64'(k) * TWO_PI_Q30) / 64'(SINE_TABLE_SIZE);
      assign rom_tbl[k] = sine_q15(THETA);
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rom_tbl[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/lfoap_stage_mem.sv @@
// ----------------------------------------------------------------------------
// lfoap_stage_mem
// Allpass delay memory: one write and one registered read per cycle, with a
// valid bit per entry so that an entry never written reads as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfoap_stage_mem #(
   parameter  int STAGES = 24,
   localparam int ADDR_W = (STAGES > 1) ? $clog2(STAGES) : 1
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 wr_en,
   input  wire logic [ADDR_W-1:0]                    wr_addr,
   input  wire logic signed [lfoap_pkg::STATE_W-1:0] wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [ADDR_W-1:0]                    rd_addr,
   output logic signed [lfoap_pkg::STATE_W-1:0]      rd_data
);
   import lfoap_pkg::*;

   logic signed [STATE_W-1:0] mem [STAGES];
   logic signed [STATE_W-1:0] rd_data_ff;
   logic                      rd_valid_ff, rd_valid_in;
   logic [STAGES-1:0]         valid_ff, valid_in;

   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ rtl/lfoap_div.sv @@
// ----------------------------------------------------------------------------
// lfoap_div
// Restoring divider for the allpass coefficient a1 = (1-d)/(1+d), rounded,
// Q2.16, one quotient bit per cycle; saturates when the quotient overflows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfoap_div (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfoap_pkg::div_req_type   div_req,
   output lfoap_pkg::div_rsp_type        div_rsp
);
   import lfoap_pkg::*;

   localparam int CNT_W = $clog2(A1_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      rem_ff, rem_in;
   logic [15:0]      den_ff, den_in;
   logic [A1_W-1:0]  dvd_ff, dvd_in;
   logic [A1_W-1:0]  q_ff, q_in;
   logic [33:0]      dividend;
   logic [16:0]      trial;
   logic             ovf;

   always_comb begin
      // num * 2^16 plus half the divisor for rounding
      dividend = {1'b0, div_req.num, 16'd0} + 34'(div_req.den[15:1]);
      ovf      = (div_req.den == 16'd0) || (dividend >= {div_req.den, 18'd0});
      trial    = {rem_ff, dvd_ff[A1_W-1]};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      dvd_in   = dvd_ff;
      q_in     = q_ff;
      if (div_req.start) begin
         den_in = div_req.den;
         if (ovf) begin
            q_in    = A1_MAX;
            done_in = 1'b1;
         end else begin
            rem_in  = dividend[33:18];
            dvd_in  = dividend[17:0];
            q_in    = '0;
            cnt_in  = CNT_W'(A1_W);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 16'(trial - {1'b0, den_ff});
            q_in   = {q_ff[A1_W-2:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in   = {q_ff[A1_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = q_ff;

endmodule

`default_nettype wire

@@ rtl/lfo_swept_allpass_phaser.sv @@
// ----------------------------------------------------------------------------
// lfo_swept_allpass_phaser
// Sequence: from an accepted beat to the result beat, one sine rom read, the
//   18-step coefficient divider, then states STAGE_A and STAGE_B for each
//   allpass section through the delay memory; the divider steps are skipped
//   when a1 saturates.
// Throughput: one sample in flight; the next beat is accepted in the cycle
//   after the result is registered, and the result waits while the previous
//   result is still held in the output register.
// Reset: synchronous; registers return to defaults, lfo phase and feedback
//   clear, and all delay entries read as zero at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfo_swept_allpass_phaser #(
   parameter int STAGES          = 24,
   parameter int SINE_TABLE_SIZE = 1024,
   parameter int SAMPLE_BITS     = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]            rsp_sample_out,
   input  wire logic                                csr_we,
   input  wire logic [lfoap_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  wire logic [lfoap_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lfoap_pkg::*;

   localparam int IDX_W  = $clog2(SINE_TABLE_SIZE);
   localparam int ADDR_W = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int GUARD  = STATE_W - SAMPLE_BITS;
   localparam int ACC_W  = 42;
   localparam int PROD_W = STATE_W + A1_W + 1;
   localparam logic signed [ACC_W-1:0] MIX_ROUND = ACC_W'(64'sd1 <<< (14 + GUARD));
   localparam logic signed [ACC_W-1:0] OUT_MAX   = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN   = -OUT_MAX - ACC_W'(1);

   phaser_state_type state_ff, state_in;

   logic signed [15:0]         d_min_ff, d_min_in;
   logic signed [15:0]         d_max_ff, d_max_in;
   logic [31:0]                phase_step_ff, phase_step_in;
   logic [14:0]                fb_gain_ff, fb_gain_in;
   logic [15:0]                wet_mix_ff, wet_mix_in;
   logic [31:0]                lfo_phase_ff, lfo_phase_in;
   logic signed [STATE_W-1:0]  chain_fb_ff, chain_fb_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic signed [STATE_W-1:0]     xs_ff, xs_in;
   logic signed [STATE_W-1:0]     cur_ff, cur_in;
   logic signed [STATE_W-1:0]     xprev_ff, xprev_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [33:0]            dprod_ff, dprod_in;
   logic [A1_W-1:0]               a1_ff, a1_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [ADDR_W-1:0]             stage_ff, stage_in;

   logic [IDX_W+32:0]             rom_prod;
   logic [IDX_W:0]                rom_idx_full;
   logic [IDX_W-1:0]              rom_addr;
   logic                          rom_rd_en;
   logic signed [15:0]            rom_data;

   logic signed [STATE_W-1:0]     xs_new;
   logic signed [39:0]            fb_prod;
   logic signed [STATE_W-1:0]     x0;
   logic [15:0]                   u16;
   logic signed [16:0]            diff17;
   logic signed [35:0]            dround;
   logic signed [35:0]            d_wide;
   logic signed [15:0]            d16;
   logic signed [17:0]            den18;
   logic signed [17:0]            num18;
   logic signed [PROD_W-1:0]      prnd;
   logic signed [PROD_W-1:0]      a1_prod;
   logic [15:0]                   w16;
   logic [15:0]                   dry16;
   logic signed [ACC_W-1:0]       mix_q;
   logic signed [SAMPLE_BITS-1:0] mix_sat;
   logic                          last_stage;

   logic                          mem_wr_en;
   logic [ADDR_W-1:0]             mem_wr_addr;
   logic signed [STATE_W-1:0]     mem_wr_data;
   logic                          mem_rd_en;
   logic [ADDR_W-1:0]             mem_rd_addr;
   logic signed [STATE_W-1:0]     mem_rd_data;

   div_req_type div_req;
   div_rsp_type div_rsp;

   lfoap_sine_rom #(
      .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
   ) u_rom (
      .clock   (clock),
      .rd_en   (rom_rd_en),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   lfoap_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   lfoap_stage_mem #(
      .STAGES(STAGES)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // shared arithmetic
   always_comb begin
      rom_prod = (IDX_W+33)'(lfo_phase_ff) * (IDX_W+33)'(SINE_TABLE_SIZE)
               + ((IDX_W+33)'(1) << 31);
      rom_idx_full = rom_prod[IDX_W+32:32];
      if (rom_idx_full >= (IDX_W+1)'(SINE_TABLE_SIZE)) begin
         rom_addr = '0;
      end else begin
         rom_addr = rom_idx_full[IDX_W-1:0];
      end

      xs_new  = STATE_W'(req_sample_in) <<< GUARD;
      fb_prod = 40'(chain_fb_ff) * 40'(signed'({1'b0, fb_gain_ff}));
      x0      = sat24(48'(xs_new) + 48'((fb_prod + 40'sd16384) >>> 15));

      // (sin + 1) / 2 in q0.16
      u16     = {~rom_data[15], rom_data[14:0]};
      diff17  = 17'(d_max_ff) - 17'(d_min_ff);

      dround  = (36'(dprod_ff) + 36'sd32768) >>> 16;
      d_wide  = 36'(d_min_ff) + dround;
      d16     = d_wide[15:0];
      den18   = 18'sd32768 + 18'(d16);
      num18   = 18'sd32768 - 18'(d16);

      prnd    = (prod_ff + PROD_W'(32768)) >>> 16;
      a1_prod = PROD_W'(cur_ff) * PROD_W'(signed'({1'b0, a1_ff}));

      w16     = (wet_mix_ff > WET_FULL) ? WET_FULL : wet_mix_ff;
      dry16   = WET_FULL - w16;

      mix_q   = acc_ff >>> (15 + GUARD);
      if (mix_q > OUT_MAX) begin
         mix_sat = OUT_MAX[SAMPLE_BITS-1:0];
      end else if (mix_q < OUT_MIN) begin
         mix_sat = OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
         mix_sat = mix_q[SAMPLE_BITS-1:0];
      end

      last_stage = (stage_ff == ADDR_W'(STAGES - 1));
   end

   // sequencer: next state, datapath loads and memory ports
   always_comb begin
      state_in      = state_ff;
      d_min_in      = d_min_ff;
      d_max_in      = d_max_ff;
      phase_step_in = phase_step_ff;
      fb_gain_in    = fb_gain_ff;
      wet_mix_in    = wet_mix_ff;
      lfo_phase_in  = lfo_phase_ff;
      chain_fb_in   = chain_fb_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      xs_in         = xs_ff;
      cur_in        = cur_ff;
      xprev_in      = xprev_ff;
      prod_in       = prod_ff;
      dprod_in      = dprod_ff;
      a1_in         = a1_ff;
      acc_in        = acc_ff;
      stage_in      = stage_ff;
      rom_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = stage_ff;
      mem_wr_data   = sat24(48'(prnd) + 48'(xprev_ff));
      mem_rd_en     = 1'b0;
      mem_rd_addr   = '0;
      div_req.start = 1'b0;
      div_req.num   = num18[16:0];
      div_req.den   = den18[15:0];

      if (csr_we) begin
         case (csr_addr)
            CSR_D_MIN:         d_min_in      = csr_wdata[15:0];
            CSR_D_MAX:         d_max_in      = csr_wdata[15:0];
            CSR_PHASE_STEP:    phase_step_in = csr_wdata[31:0];
            CSR_FEEDBACK_GAIN: fb_gain_in    = csr_wdata[14:0];
            CSR_WET_MIX:       wet_mix_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               xs_in        = xs_new;
               cur_in       = x0;
               lfo_phase_in = lfo_phase_ff + phase_step_ff;
               rom_rd_en    = 1'b1;
               state_in     = ST_ROM;
            end
         end
         ST_ROM: begin
            dprod_in = 34'(diff17) * 34'(signed'({1'b0, u16}));
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               a1_in    = div_rsp.quot;
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            prod_in   = a1_prod;
            stage_in  = '0;
            mem_rd_en = 1'b1;
            state_in  = ST_STAGE_A;
         end
         ST_STAGE_A: begin
            // prod holds this section's input times a1, which is also the
            // previous section's output times a1 for its delay update
            cur_in      = sat24(48'(mem_rd_data) - 48'(prnd));
            xprev_in    = cur_ff;
            mem_wr_en   = (stage_ff != '0);
            mem_wr_addr = stage_ff - ADDR_W'(1);
            state_in    = ST_STAGE_B;
         end
         ST_STAGE_B: begin
            prod_in = a1_prod;
            if (last_stage) begin
               state_in = ST_WB;
            end else begin
               stage_in    = stage_ff + ADDR_W'(1);
               mem_rd_en   = 1'b1;
               mem_rd_addr = stage_ff + ADDR_W'(1);
               state_in    = ST_STAGE_A;
            end
         end
         ST_WB: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = stage_ff;
            chain_fb_in = cur_ff;
            acc_in      = ACC_W'(signed'({1'b0, dry16})) * ACC_W'(xs_ff);
            state_in    = ST_MIX;
         end
         ST_MIX: begin
            acc_in   = acc_ff + ACC_W'(signed'({1'b0, w16})) * ACC_W'(cur_ff) + MIX_ROUND;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = mix_sat;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         d_min_ff      <= D_MIN_RESET;
         d_max_ff      <= D_MAX_RESET;
         phase_step_ff <= PHASE_STEP_RESET;
         fb_gain_ff    <= FB_GAIN_RESET;
         wet_mix_ff    <= WET_MIX_RESET;
         lfo_phase_ff  <= '0;
         chain_fb_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         stage_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         d_min_ff      <= d_min_in;
         d_max_ff      <= d_max_in;
         phase_step_ff <= phase_step_in;
         fb_gain_ff    <= fb_gain_in;
         wet_mix_ff    <= wet_mix_in;
         lfo_phase_ff  <= lfo_phase_in;
         chain_fb_ff   <= chain_fb_in;
         rsp_valid_ff  <= rsp_valid_in;
         stage_ff      <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sample_ff <= rsp_sample_in;
      xs_ff         <= xs_in;
      cur_ff        <= cur_in;
      xprev_ff      <= xprev_in;
      prod_ff       <= prod_in;
      dprod_ff      <= dprod_in;
      a1_ff         <= a1_in;
      acc_ff        <= acc_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the swept allpass phaser. A scoreboard class keeps
// its own fixed-point copy of the lfo, sine table, allpass chain and mix, and
// predicts each phased sample when an input beat is accepted. Directed beats
// cover the sample extremes and the corner settings: d at minus one, large
// a1, swapped bounds, wet above one and full feedback. Random phases with
// fresh register settings follow. Both channels idle at random; one phase
// holds the output off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import lfoap_pkg::*;

   localparam int STAGE_COUNT  = 24;
   localparam int SINE_POINTS  = 1024;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1870;
   localparam int LONG_HOLD    = 800;
   localparam int MAX_REPORTS  = 40;

   class phaser_scoreboard;
      int                 errors;
      logic signed [15:0] phased_q[$];
      int                 sine_tab[SINE_POINTS];

      logic [15:0]        d_min_r;
      logic [15:0]        d_max_r;
      logic [31:0]        step_r;
      logic [14:0]        fb_gain_r;
      logic [15:0]        wet_r;

      logic signed [23:0] delay_line[STAGE_COUNT];
      logic signed [23:0] fb_state;
      logic [31:0]        lfo_phase;

      function new();
         errors = 0;
         for (int k = 0; k < SINE_POINTS; k++) begin
            sine_tab[k] = sine_point(k);
         end
         d_min_r   = D_MIN_RESET;
         d_max_r   = D_MAX_RESET;
         step_r    = PHASE_STEP_RESET;
         fb_gain_r = FB_GAIN_RESET;
         wet_r     = WET_MIX_RESET;
         for (int i = 0; i < STAGE_COUNT; i++) begin
            delay_line[i] = '0;
         end
         fb_state  = '0;
         lfo_phase = '0;
      endfunction

      // q30 taylor series of sin over the first quarter, mirrored
      function int sine_point(int k);
         longint unsigned th;
         longint unsigned x2;
         longint unsigned term;
         longint          acc;
         bit              neg;
         th  = (longint'(k) * 64'd6746518852) / SINE_POINTS;
         neg = 1'b0;
         if (th > 64'd3373259426) begin
            th  = th - 64'd3373259426;
            neg = 1'b1;
         end
         if (th > 64'd1686629713) begin
            th = (th > 64'd3373259426) ? 64'd0 : 64'd3373259426 - th;
         end
         x2   = (th * th) >> 30;
         term = th;
         acc  = longint'(th);
         for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         if (acc > 64'sd1073741824) begin
            acc = 64'sd1073741824;
         end
         acc = (acc * 32767 + 64'sd536870912) >>> 30;
         return neg ? -int'(acc) : int'(acc);
      endfunction

      function logic signed [23:0] clip24(longint v);
         if (v > 64'sd8388607) begin
            return 24'sh7fffff;
         end
         if (v < -64'sd8388608) begin
            return 24'sh800000;
         end
         return 24'(v);
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] v);
         case (idx)
            CSR_D_MIN:         d_min_r   = v[15:0];
            CSR_D_MAX:         d_max_r   = v[15:0];
            CSR_PHASE_STEP:    step_r    = v;
            CSR_FEEDBACK_GAIN: fb_gain_r = v[14:0];
            CSR_WET_MIX:       wet_r     = v[15:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return phased_q.size();
      endfunction

      // one accepted input beat: advance the lfo and the chain, queue the mix
      function void accept_sample(logic signed [15:0] x);
         longint unsigned pos;
         longint          u;
         longint          dlo;
         longint          dhi;
         longint          d;
         longint          den;
         longint          num;
         longint          a1;
         longint          g;
         longint          w;
         longint          xs;
         longint          y;
         longint          t;
         longint          mix;
         pos = ({32'd0, lfo_phase} * 64'd1024 + 64'h8000_0000) >> 32;
         if (pos >= SINE_POINTS) begin
            pos = 0;
         end
         u         = sine_tab[pos] + 32768;
         lfo_phase = lfo_phase + step_r;

         dlo = $signed(d_min_r);
         dhi = $signed(d_max_r);
         d   = dlo + (((dhi - dlo) * u + 32768) >>> 16);
         den = 32768 + d;
         num = 32768 - d;
         if (den <= 0) begin
            a1 = 262143;
         end else begin
            a1 = (num * 65536 + den / 2) / den;
            if (a1 > 262143) begin
               a1 = 262143;
            end
         end

         g  = fb_gain_r;
         xs = longint'(x) * 256;
         y  = clip24(xs + ((fb_state * g + 16384) >>> 15));
         for (int i = 0; i < STAGE_COUNT; i++) begin
            t             = y;
            y             = clip24(delay_line[i] - ((t * a1 + 32768) >>> 16));
            delay_line[i] = clip24(((y * a1 + 32768) >>> 16) + t);
         end
         fb_state = 24'(y);

         w = wet_r;
         if (w > 32768) begin
            w = 32768;
         end
         mix = ((32768 - w) * xs + w * y + 64'sd4194304) >>> 23;
         if (mix > 32767) begin
            mix = 32767;
         end else if (mix < -32768) begin
            mix = -32768;
         end
         phased_q.push_back(16'(mix));
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("mismatch: %s", what);
         end
      endtask

      task check_sample(logic signed [15:0] got);
         logic signed [15:0] want;
         if (phased_q.size() == 0) begin
            report($sformatf("sample_out %0d with nothing expected", got));
            return;
         end
         want = phased_q.pop_front();
         if (got !== want) begin
            report($sformatf("sample_out got %0d want %0d", got, want));
         end
      endtask
   endclass

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic signed [15:0]            req_sample_in  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic signed [15:0]            rsp_sample_out;
   logic                          csr_we         = 1'b0;
   logic [CSR_ADDR_W-1:0]         csr_addr       = '0;
   logic [CSR_DATA_W-1:0]         csr_wdata      = '0;

   phaser_scoreboard   sb;
   logic signed [15:0] sample_list[$];
   int                 cycle_count = 0;
   int                 sent_count  = 0;
   int                 long_hold   = 0;
   bit                 rsp_quiet   = 1'b0;

   lfo_swept_allpass_phaser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL lfo_swept_allpass_phaser");
         $finish;
      end
   end

   function automatic logic [15:0] pick_bound();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'hc000;
         2: return 16'h7fff;
         3: return 16'($urandom);
         default: return 16'($urandom_range(0, 49151) - 16384);
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hffff_ffff;
         2: return $urandom;
         default: return $urandom_range(0, 200000);
      endcase
   endfunction

   function automatic logic [14:0] pick_fb_gain();
      case ($urandom_range(0, 5))
         0: return 15'd0;
         1: return 15'd32440;
         2: return 15'h7fff;
         3: return 15'($urandom);
         default: return 15'($urandom_range(0, 32440));
      endcase
   endfunction

   function automatic logic [15:0] pick_wet();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'h8000;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 32768));
      endcase
   endfunction

   function automatic logic signed [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return 16'($urandom_range(0, 255) - 128);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_one(input csr_index_type idx, input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      @(posedge clock);
      sb.write_reg(idx, v);
   endtask

   task automatic program_regs(input logic [15:0] dmin, input logic [15:0] dmax,
                               input logic [31:0] step, input logic [14:0] fb,
                               input logic [15:0] wet);
      write_one(CSR_D_MIN, {16'd0, dmin});
      write_one(CSR_D_MAX, {16'd0, dmax});
      write_one(CSR_PHASE_STEP, step);
      write_one(CSR_FEEDBACK_GAIN, {17'd0, fb});
      write_one(CSR_WET_MIX, {16'd0, wet});
      csr_we <= 1'b0;
   endtask

   task automatic send_sample(input logic signed [15:0] x, input int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.accept_sample(x);
      sent_count++;
   endtask

   // send the queued list, then hold the input until every result is back
   task automatic send_list(input bit quiet);
      while (sample_list.size() != 0) begin
         send_sample(sample_list.pop_front(), quiet ? 0 : $urandom_range(0, 13));
      end
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : rsp_side
      int n;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_hold != 0) begin
            n         = long_hold;
            long_hold = 0;
         end else if (rsp_quiet) begin
            n = 0;
         end else begin
            n = $urandom_range(0, 13);
         end
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         sb.check_sample(rsp_sample_out);
      end
   end

   initial begin : req_side
      int phase_no;
      bit quiet;
      int n;
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults, sample extremes
      sample_list = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd1, -16'sd1, 16'sh5a5a};
      send_list(1'b0);

      // d at minus one, full feedback field, wet above one, phase wraps the table
      program_regs(16'h8000, 16'h8000, 32'hffff_ffff, 15'h7fff, 16'hffff);
      sample_list = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0};
      send_list(1'b0);

      // swapped bounds, dry only, no feedback
      program_regs(16'h7fff, 16'hc000, 32'h8000_0000, 15'd0, 16'd0);
      sample_list = '{16'sh7fff, 16'sh8000, 16'sh1234, -16'sh4321};
      send_list(1'b1);

      // d just above minus one drives a1 into saturation, all wet
      program_regs(16'h8001, 16'h8ad0, 32'h4000_0000, 15'd32440, 16'h8000);
      sample_list = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0f0f, 16'shf0f0};
      send_list(1'b0);

      phase_no = 0;
      while (sent_count < RANDOM_ITEMS) begin
         program_regs(pick_bound(), pick_bound(), pick_step(), pick_fb_gain(), pick_wet());
         quiet     = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         n         = $urandom_range(20, 60);
         if (phase_no == 5) begin
            // output held off while the input keeps offering beats
            long_hold = LONG_HOLD;
            quiet     = 1'b1;
         end
         repeat (n) sample_list.push_back(pick_sample());
         send_list(quiet);
         phase_no++;
      end

      rsp_quiet = 1'b0;
      repeat (80) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      end
      if (sb.errors == 0) begin
         $display("PASS lfo_swept_allpass_phaser");
      end else begin
         $display("FAIL lfo_swept_allpass_phaser");
      end
      $finish;
   end

endmodule
